// File: sv/bsbd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsbd_pkg: shared types for the bitmap sparse block decoder
// Word kinds, the queue entry and status, and the back-end state type.
// ----------------------------------------------------------------------------
package bsbd_pkg;

  // width of the stream word and of the sample field
  localparam int IN_W = 32;

  // what a stream word means at its place in a block
  typedef enum logic [1:0] {
    KIND_BASE  = 2'd0,
    KIND_MASK  = 2'd1,
    KIND_VALUE = 2'd2
  } kind_t;

  // one classified word in the queue between front and back
  typedef struct packed {
    kind_t            kind;
    logic [IN_W-1:0]  word;
  } q_item_t;

  // queue status seen by both ends
  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

  // back-end sequencer states
  typedef enum logic {
    BK_FETCH = 1'b0,
    BK_RUN   = 1'b1
  } back_state_t;

endpackage

// File: sv/bitmap_sparse_block_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_sparse_block_decoder: bitmap zero-suppression block decoder
// Turns a word stream of base, mask and value words into sample blocks.
// ----------------------------------------------------------------------------
// Each block is a base word, a mask word (low BLOCK_SIZE bits, sample 0 at
// the top bit) and one value word per set mask bit; the block gives
// BLOCK_SIZE samples, base plus value on set bits and the base alone on
// clear ones, the final one flagged by out_tlast. Words are taken one per
// cycle while the QUEUE_DEPTH-entry queue has room. The sample sequencer
// takes a base word by itself, a mask word followed by the samples for its
// leading clear bits and a turnaround back to fetch, and a value word with
// its own sample followed by the samples for the clear bits after it and a
// turnaround back to fetch; samples leave at most one per cycle.
// ----------------------------------------------------------------------------
module bitmap_sparse_block_decoder import bsbd_pkg::*; #(
  parameter int BLOCK_SIZE  = 16,
  parameter int WORD_WIDTH  = 32,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_W-1:0]   in_tdata,   // [31:0] word
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [IN_W-1:0]   out_tdata,  // [31:0] sample
  output logic              out_tlast
);

  q_status_t  q_status;
  q_item_t    push_item;
  q_item_t    head_item;
  logic       q_push;
  logic       q_pop;

  // classifier
  bsbd_front #(
    .BLOCK_SIZE (BLOCK_SIZE)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_status  (q_status),
    .q_push    (q_push),
    .q_item    (push_item)
  );

  // request queue
  bsbd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .pop       (q_pop),
    .head_item (head_item),
    .status    (q_status)
  );

  // sample sequencer
  bsbd_back #(
    .BLOCK_SIZE (BLOCK_SIZE),
    .WORD_WIDTH (WORD_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_item  (head_item),
    .q_status   (q_status),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// File: sv/bsbd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsbd_front: input classifier
// Accepts stream words, tags each as base, mask or value, and tracks how
// many value words the current mask still calls for.
// ----------------------------------------------------------------------------
module bsbd_front import bsbd_pkg::*; #(
  parameter int BLOCK_SIZE = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_W-1:0]   in_tdata,   // [31:0] word
  input  q_status_t         q_status,
  output logic              q_push,
  output q_item_t           q_item
);

  kind_t                  phase_r, phase_nxt;
  logic [BLOCK_SIZE-1:0]  rem_r, rem_nxt;
  logic [BLOCK_SIZE-1:0]  rem_dec;
  logic [BLOCK_SIZE-1:0]  in_mask;

  // handshake into the queue
  assign in_tready   = !q_status.full;
  assign q_push      = in_tvalid && !q_status.full;
  assign q_item.kind = phase_r;
  assign q_item.word = in_tdata;

  assign in_mask = in_tdata[BLOCK_SIZE-1:0];
  // drop one set bit per value word; only the count matters
  assign rem_dec = rem_r & (rem_r - BLOCK_SIZE'(1));

  // phase tracking
  always_comb begin
    phase_nxt = phase_r;
    rem_nxt   = rem_r;
    if (q_push) begin
      case (phase_r)
        KIND_MASK: begin
          rem_nxt   = in_mask;
          phase_nxt = (in_mask == '0) ? KIND_BASE : KIND_VALUE;
        end
        KIND_VALUE: begin
          rem_nxt   = rem_dec;
          phase_nxt = (rem_dec == '0) ? KIND_BASE : KIND_VALUE;
        end
        default: begin
          phase_nxt = KIND_MASK;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= KIND_BASE;
      rem_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      rem_r   <= rem_nxt;
    end
  end

  // value phase always has value words outstanding
  a_value_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == KIND_VALUE) |-> (rem_r != '0))
    else $error("value phase with no set mask bits left");

endmodule

// File: sv/bsbd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsbd_queue: short request queue
// Register FIFO that decouples the classifier from the sample sequencer.
// ----------------------------------------------------------------------------
module bsbd_queue import bsbd_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  q_item_t   push_item,
  input  logic      pop,
  output q_item_t   head_item,
  output q_status_t status
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  q_item_t        mem_r [DEPTH];
  logic [AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic           do_push, do_pop;

  assign status.empty = (count_r == '0);
  assign status.full  = (count_r == CW'(DEPTH));
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head_item    = mem_r[rd_ptr_r];

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage, no reset
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  // a push into a full queue would lose a word
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !status.full)
    else $error("push into full queue");

endmodule

// File: sv/bsbd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsbd_back: sample sequencer
// Takes classified words from the queue, holds base and mask, and emits at most
// one sample per cycle into the output register while that register has room.
// ----------------------------------------------------------------------------
module bsbd_back import bsbd_pkg::*; #(
  parameter int BLOCK_SIZE = 16,
  parameter int WORD_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  q_item_t           head_item,
  input  q_status_t         q_status,
  output logic              q_pop,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [IN_W-1:0]   out_tdata,  // [31:0] sample
  output logic              out_tlast
);

  localparam int PW = $clog2(BLOCK_SIZE + 1);
  localparam logic [PW-1:0] LAST_POS = PW'(BLOCK_SIZE - 1);
  localparam logic [PW-1:0] END_POS  = PW'(BLOCK_SIZE);

  back_state_t                   state_r, state_nxt;
  logic signed [WORD_WIDTH-1:0]  base_r, base_nxt;
  logic [BLOCK_SIZE-1:0]         mask_r, mask_nxt;
  logic [PW-1:0]                 pos_r, pos_nxt;
  logic                          out_valid_r;
  logic [IN_W-1:0]               out_sample_r, sample_nxt;
  logic                          out_last_r, last_nxt;
  logic                          load;
  logic                          slot_free;
  logic signed [WORD_WIDTH-1:0]  word_w;
  logic signed [WORD_WIDTH-1:0]  sum_w;

  assign slot_free  = !out_valid_r || out_tready;
  assign word_w     = WORD_WIDTH'(signed'(head_item.word));
  assign sum_w      = base_r + word_w;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_sample_r;
  assign out_tlast  = out_last_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_FETCH: begin
        if (q_pop && (head_item.kind == KIND_MASK || head_item.kind == KIND_VALUE)) begin
          state_nxt = BK_RUN;
        end
      end
      BK_RUN: begin
        if (pos_r == END_POS || mask_r[BLOCK_SIZE-1]) begin
          state_nxt = BK_FETCH;
        end
      end
      default: state_nxt = BK_FETCH;
    endcase
  end

  // datapath control
  always_comb begin
    q_pop      = 1'b0;
    load       = 1'b0;
    sample_nxt = IN_W'(base_r);
    last_nxt   = (pos_r == LAST_POS);
    base_nxt   = base_r;
    mask_nxt   = mask_r;
    pos_nxt    = pos_r;
    case (state_r)
      BK_FETCH: begin
        if (!q_status.empty) begin
          case (head_item.kind)
            KIND_MASK: begin
              q_pop    = 1'b1;
              mask_nxt = head_item.word[BLOCK_SIZE-1:0];
              pos_nxt  = '0;
            end
            KIND_VALUE: begin
              // the current mask bit is set: this word is its value
              if (slot_free) begin
                q_pop      = 1'b1;
                load       = 1'b1;
                sample_nxt = IN_W'(sum_w);
                mask_nxt   = mask_r << 1;
                pos_nxt    = pos_r + PW'(1);
              end
            end
            default: begin
              q_pop    = 1'b1;
              base_nxt = word_w;
            end
          endcase
        end
      end
      BK_RUN: begin
        if (pos_r == END_POS) begin
          pos_nxt = '0;
        end else if (!mask_r[BLOCK_SIZE-1] && slot_free) begin
          // clear position: sample is the base alone
          load     = 1'b1;
          mask_nxt = mask_r << 1;
          pos_nxt  = pos_r + PW'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_FETCH;
      base_r      <= '0;
      mask_r      <= '0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      base_r  <= base_nxt;
      mask_r  <= mask_nxt;
      pos_r   <= pos_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (load) begin
      out_sample_r <= sample_nxt;
      out_last_r   <= last_nxt;
    end
  end

  // position never runs past the block end
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= END_POS)
    else $error("position beyond block end");

  // a value word only arrives on a set mask position
  a_value_on_set_bit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_FETCH && q_pop && head_item.kind == KIND_VALUE)
      |-> (mask_r[BLOCK_SIZE-1] && pos_r != END_POS))
    else $error("value word for a clear position");

  // the last sample of a block closes the block
  a_last_ends_block: assert property (@(posedge clk) disable iff (!rst_n)
    (load && last_nxt) |=> (pos_r == END_POS))
    else $error("last flag without block end");

endmodule
